// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

	localparam int CAPACITY   = 16;
	localparam int WORD_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_NONE       = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_LOAD
	} deq_state_t;

	typedef struct packed {
		logic latch_in;
		logic rd_pop;
		logic exec;
		logic load_out;
	} deq_cmd_t;

	typedef struct packed {
		logic out_busy;
	} deq_stat_t;

	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (s >= (CNT_W + 1)'(CAPACITY)) begin
			s = s - (CNT_W + 1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_prev(idx_t base);
		return (base == '0) ? IDX_W'(CAPACITY - 1) : base - IDX_W'(1);
	endfunction

	function automatic idx_t ring_next(idx_t base);
		return (base == IDX_W'(CAPACITY - 1)) ? '0 : base + IDX_W'(1);
	endfunction

endpackage

// ===== sv/deq_if.sv =====
`timescale 1ns / 1ps

interface deq_req_if;
	logic                valid;
	logic                ready;
	logic [2:0]          action;
	deq_pkg::word_t      push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink (input valid, input action, input push_value, output ready);
endinterface

interface deq_rsp_if;
	logic                valid;
	logic                ready;
	deq_pkg::word_t      front_value;
	deq_pkg::word_t      back_value;
	deq_pkg::word_t      popped_value;
	logic                popped_valid;
	logic                rejected;
	deq_pkg::cnt_t       occupancy;
	logic                is_empty;
	logic                is_full;

	modport source (
		output valid, output front_value, output back_value, output popped_value,
		output popped_valid, output rejected, output occupancy, output is_empty,
		output is_full, input ready
	);
	modport sink (
		input valid, input front_value, input back_value, input popped_value,
		input popped_valid, input rejected, input occupancy, input is_empty,
		input is_full, output ready
	);
endinterface

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed words held in a ring store.
// Channels: req carries action and push_value; rsp carries one result per
// request with the front and back words (all ones when empty), the popped
// word, popped_valid, rejected, occupancy, is_empty and is_full.
// A request is taken when valid and ready are both high on a rising edge.
// A request passes through the operate step (EXEC), a registered read of
// the ring store (READ) and the load into the output register (LOAD).
// Ready is high only in idle, so the next request waits for that load.
// A push when full or a pop when empty leaves the queue unchanged and sets
// rejected. Reset (arst_n low) empties the queue and drops any pending
// result; store contents are not cleared.
// While the receiver stalls a result, it holds and the next request is taken
// and worked on up to the output register.
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;
	logic               ready;

	assign req.ready = ready;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (req.action),
		.push_value (req.push_value),
		.rsp        (rsp)
	);

endmodule

// ===== sv/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);

	deq_pkg::deq_state_t state_q;
	deq_pkg::deq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					cmd.rd_pop   = 1'b1;
					state_d      = deq_pkg::ST_EXEC;
				end
			end
			deq_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = deq_pkg::ST_READ;
			end
			deq_pkg::ST_READ: begin
				state_d = deq_pkg::ST_LOAD;
			end
			deq_pkg::ST_LOAD: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = deq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/deq_dpath.sv =====
`timescale 1ns / 1ps

module deq_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::deq_cmd_t  cmd,
	output deq_pkg::deq_stat_t stat,
	input  logic [2:0]         action,
	input  deq_pkg::word_t     push_value,
	deq_rsp_if.source          rsp
);

	deq_pkg::word_t mem [deq_pkg::CAPACITY];

	logic [2:0]     op_q;
	deq_pkg::word_t word_q;
	deq_pkg::idx_t  head_q;
	deq_pkg::cnt_t  count_q;
	deq_pkg::word_t rd_a_q;
	deq_pkg::word_t rd_b_q;
	deq_pkg::word_t popped_q;
	logic           popped_valid_q;
	logic           rejected_q;

	deq_pkg::word_t front_value_q;
	deq_pkg::word_t back_value_q;
	deq_pkg::word_t popped_value_q;
	logic           out_popped_valid_q;
	logic           out_rejected_q;
	deq_pkg::cnt_t  occupancy_q;
	logic           is_empty_q;
	logic           is_full_q;
	logic           rsp_valid_q;

	deq_pkg::idx_t  back_idx;
	deq_pkg::idx_t  pop_idx;
	deq_pkg::idx_t  rd_a_idx;
	deq_pkg::idx_t  head_d;
	deq_pkg::cnt_t  count_d;
	deq_pkg::idx_t  wr_idx;
	logic           wr_en;
	logic           pop_ok;
	logic           reject;
	logic           full;
	logic           empty;

	assign full     = (count_q == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign back_idx = deq_pkg::ring_add(head_q, count_q - deq_pkg::CNT_W'(1));
	assign pop_idx  = (action == deq_pkg::ACT_POP_BACK) ? back_idx : head_q;
	assign rd_a_idx = cmd.rd_pop ? pop_idx : head_q;

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		wr_idx  = head_q;
		wr_en   = 1'b0;
		pop_ok  = 1'b0;
		reject  = 1'b0;
		case (op_q) inside
			deq_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					reject = 1'b1;
				end else begin
					head_d  = deq_pkg::ring_prev(head_q);
					wr_idx  = head_d;
					wr_en   = 1'b1;
					count_d = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					reject = 1'b1;
				end else begin
					wr_idx  = deq_pkg::ring_add(head_q, count_q);
					wr_en   = 1'b1;
					count_d = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
				if (empty) begin
					reject = 1'b1;
				end else begin
					pop_ok  = 1'b1;
					count_d = count_q - deq_pkg::CNT_W'(1);
					if (op_q == deq_pkg::ACT_POP_FRONT) begin
						head_d = deq_pkg::ring_next(head_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// store and read ports
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_idx] <= word_q;
		end
		rd_a_q <= mem[rd_a_idx];
		rd_b_q <= mem[back_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= action;
			word_q <= push_value;
		end
		if (cmd.exec) begin
			popped_q <= pop_ok ? rd_a_q : '0;
		end
		if (cmd.load_out) begin
			front_value_q      <= empty ? '1 : rd_a_q;
			back_value_q       <= empty ? '1 : rd_b_q;
			popped_value_q     <= popped_q;
			out_popped_valid_q <= popped_valid_q;
			out_rejected_q     <= rejected_q;
			occupancy_q        <= count_q;
			is_empty_q         <= empty;
			is_full_q          <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			popped_valid_q <= 1'b0;
			rejected_q     <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q         <= head_d;
				count_q        <= count_d;
				popped_valid_q <= pop_ok;
				rejected_q     <= reject;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = rsp_valid_q && !rsp.ready;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.front_value  = front_value_q;
	assign rsp.back_value   = back_value_q;
	assign rsp.popped_value = popped_value_q;
	assign rsp.popped_valid = out_popped_valid_q;
	assign rsp.rejected     = out_rejected_q;
	assign rsp.occupancy    = occupancy_q;
	assign rsp.is_empty     = is_empty_q;
	assign rsp.is_full      = is_full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_count_only_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> count_q == $past(count_q))
		else $error("occupancy moved outside an operation");

	a_pop_xor_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(out_popped_valid_q && out_rejected_q))
		else $error("request both popped and rejected");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (is_empty_q == (occupancy_q == '0)))
		else $error("empty flag disagrees with occupancy");

endmodule

// ===== bench/double_ended_queue_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_test;

	localparam logic [2:0] ACT_SPARE_5 = 3'd5;
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam int RANDOM_REQUESTS = 672;
	localparam int HOLD_AT_RESULT  = 200;
	localparam int HOLD_CYCLES     = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_LIMIT     = 1000;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} traffic_mix_t;

	typedef struct packed {
		deq_pkg::word_t front;
		deq_pkg::word_t back;
		deq_pkg::word_t popped;
		logic           popped_valid;
		logic           rejected;
		deq_pkg::cnt_t  occupancy;
		logic           is_empty;
		logic           is_full;
	} deq_result_t;

	typedef struct packed {
		logic [2:0]     action;
		deq_pkg::word_t value;
		logic [4:0]     count;
		logic           typed;
		deq_result_t    result;
	} stim_row_t;

	localparam deq_result_t UNTYPED = '0;
	localparam deq_result_t EMPTY_REJECTED = '{front: '1, back: '1, popped: '0,
		popped_valid: 1'b0, rejected: 1'b1, occupancy: '0, is_empty: 1'b1, is_full: 1'b0};
	localparam deq_result_t EMPTY_IDLE = '{front: '1, back: '1, popped: '0,
		popped_valid: 1'b0, rejected: 1'b0, occupancy: '0, is_empty: 1'b1, is_full: 1'b0};
	localparam deq_result_t ONE_MAX = '{front: 32'h7FFF_FFFF, back: 32'h7FFF_FFFF,
		popped: '0, popped_valid: 1'b0, rejected: 1'b0, occupancy: 5'd1, is_empty: 1'b0,
		is_full: 1'b0};
	localparam deq_result_t MIN_MAX = '{front: 32'h8000_0000, back: 32'h7FFF_FFFF,
		popped: '0, popped_valid: 1'b0, rejected: 1'b0, occupancy: 5'd2, is_empty: 1'b0,
		is_full: 1'b0};

	localparam stim_row_t DIRECTED [21] = '{
		'{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, EMPTY_REJECTED},
		'{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, EMPTY_REJECTED},
		'{deq_pkg::ACT_NONE,       32'h1234_5678, 5'd1,  1'b1, EMPTY_IDLE},
		'{ACT_SPARE_7,             32'hFFFF_FFFF, 5'd1,  1'b1, EMPTY_IDLE},
		'{deq_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b1, ONE_MAX},
		'{deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1, MIN_MAX},
		'{deq_pkg::ACT_PUSH_BACK,  32'h0000_0000, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b0, UNTYPED},
		'{ACT_SPARE_5,             32'hA5A5_A5A5, 5'd1,  1'b0, UNTYPED},
		'{ACT_SPARE_6,             32'h5A5A_5A5A, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_PUSH_BACK,  32'h5555_5555, 5'd14, 1'b0, UNTYPED},
		'{deq_pkg::ACT_PUSH_FRONT, 32'h0F0F_0F0F, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_PUSH_BACK,  32'hF0F0_F0F0, 5'd1,  1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd8,  1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd8,  1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, EMPTY_REJECTED},
		'{deq_pkg::ACT_PUSH_FRONT, 32'hDEAD_BEEF, 5'd16, 1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd16, 1'b0, UNTYPED},
		'{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, EMPTY_REJECTED}
	};

	logic clk = 1'b0;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	deq_pkg::word_t shadow_words [deq_pkg::CAPACITY];
	int             shadow_head;
	int             shadow_count;
	deq_result_t    pending_results [$];
	int             requests_sent;
	int             results_seen;
	int             failures;

	function automatic deq_result_t apply_action(logic [2:0] action, deq_pkg::word_t value);
		deq_result_t r;
		r = '0;
		case (action) inside
			deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
				if (shadow_count == deq_pkg::CAPACITY) begin
					r.rejected = 1'b1;
				end else if (action == deq_pkg::ACT_PUSH_FRONT) begin
					shadow_head = (shadow_head + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
					shadow_words[shadow_head] = value;
					shadow_count++;
				end else begin
					shadow_words[(shadow_head + shadow_count) % deq_pkg::CAPACITY] = value;
					shadow_count++;
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
				if (shadow_count == 0) begin
					r.rejected = 1'b1;
				end else begin
					r.popped_valid = 1'b1;
					if (action == deq_pkg::ACT_POP_FRONT) begin
						r.popped = shadow_words[shadow_head];
						shadow_head = (shadow_head + 1) % deq_pkg::CAPACITY;
					end else begin
						r.popped = shadow_words[(shadow_head + shadow_count - 1) %
							deq_pkg::CAPACITY];
					end
					shadow_count--;
				end
			end
			default: ;
		endcase
		if (shadow_count == 0) begin
			r.front = '1;
			r.back  = '1;
		end else begin
			r.front = shadow_words[shadow_head];
			r.back  = shadow_words[(shadow_head + shadow_count - 1) % deq_pkg::CAPACITY];
		end
		r.occupancy = deq_pkg::cnt_t'(shadow_count);
		r.is_empty  = (shadow_count == 0);
		r.is_full   = (shadow_count == deq_pkg::CAPACITY);
		return r;
	endfunction

	task automatic send_request(logic [2:0] action, deq_pkg::word_t value, logic typed,
		deq_result_t typed_result);
		int          gap;
		deq_result_t predicted;
		gap = (((requests_sent / 50) % 3) == 1) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= action;
		req_ch.push_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_action(action, value);
		pending_results = {pending_results, (typed ? typed_result : predicted)};
		requests_sent++;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	function automatic deq_pkg::word_t pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			4: return deq_pkg::word_t'($urandom_range(0, 255));
			default: return deq_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic logic [2:0] pick_action(traffic_mix_t mix);
		int roll;
		int push_share;
		roll = $urandom_range(0, 99);
		push_share = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
		if (roll < 4) begin
			return 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
		end else if (roll < 8) begin
			return deq_pkg::ACT_NONE;
		end else if ($urandom_range(0, 99) < push_share) begin
			return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
		end else begin
			return $urandom_range(0, 1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
		end
	endfunction

	initial begin
		traffic_mix_t mix;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.action     <= deq_pkg::ACT_NONE;
		req_ch.push_value <= '0;
		rsp_ch.ready      <= 1'b0;
		shadow_head   = 0;
		shadow_count  = 0;
		requests_sent = 0;
		results_seen  = 0;
		failures      = 0;
		mix           = MIX_EVEN;
		foreach (shadow_words[i]) shadow_words[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			for (int j = 0; j < DIRECTED[i].count; j++) begin
				send_request(DIRECTED[i].action, DIRECTED[i].value, DIRECTED[i].typed,
					DIRECTED[i].result);
			end
		end

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				mix = traffic_mix_t'($urandom_range(0, 2));
			end
			send_request(pick_action(mix), pick_word(), 1'b0, UNTYPED);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("double_ended_queue: match");
		end else begin
			$display("double_ended_queue: mismatch");
		end
		$finish;
	end

	initial begin
		int          stall;
		deq_result_t want;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (results_seen == HOLD_AT_RESULT) begin
				stall = HOLD_CYCLES;
			end else if (((results_seen / 60) % 3) == 1) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 9);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				failures++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				compare_field("front_value", want.front, rsp_ch.front_value);
				compare_field("back_value", want.back, rsp_ch.back_value);
				compare_field("popped_value", want.popped, rsp_ch.popped_value);
				compare_field("popped_valid", 32'(want.popped_valid),
					32'(rsp_ch.popped_valid));
				compare_field("rejected", 32'(want.rejected), 32'(rsp_ch.rejected));
				compare_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
				compare_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
				compare_field("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("double_ended_queue: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ctrl.sv
sv/deq_dpath.sv
sv/double_ended_queue.sv
bench/double_ended_queue_test.sv
